@@ rtl/abme_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abme_pkg
// Shared field widths, operation and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package abme_pkg;

	localparam int VID_W      = 6;
	localparam int FUNC_W     = 3;
	localparam int STAT_W     = 3;
	localparam int CNT_W      = 13;
	localparam int VCNT_W     = 7;
	localparam int NSQ_W      = 2 * VCNT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int CHUNK_MAX  = 8;

	localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RECOUNT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
	localparam logic [STAT_W-1:0] ST_SELF  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_LOOPS   = 2'd2;

	localparam logic [VCNT_W-1:0] VCNT_RST     = 7'd64;
	localparam logic              DIRECTED_RST = 1'b0;
	localparam logic              SELF_RST     = 1'b1;

	typedef logic [1:0] rsel_t;
	localparam rsel_t RS_ROW_A   = 2'd0;
	localparam rsel_t RS_ROW_B   = 2'd1;
	localparam rsel_t RS_ROW_CNT = 2'd2;

	typedef logic [1:0] wsel_t;
	localparam wsel_t WS_ROW_A = 2'd0;
	localparam wsel_t WS_ROW_B = 2'd1;
	localparam wsel_t WS_ZERO  = 2'd2;

	typedef logic [2:0] cop_t;
	localparam cop_t CO_HOLD = 3'd0;
	localparam cop_t CO_INC  = 3'd1;
	localparam cop_t CO_DEC  = 3'd2;
	localparam cop_t CO_CLR  = 3'd3;
	localparam cop_t CO_LOAD = 3'd4;

	typedef struct packed {
		logic  item_ld;
		logic  eval;
		logic  mem_rd;
		rsel_t rd_sel;
		logic  mem_wr;
		wsel_t wr_sel;
		cop_t  cnt_op;
		logic  row_clr;
		logic  row_inc;
		logic  acc_clr;
		logic  row_ld;
		logic  chunk_step;
		logic  res_ld;
	} abme_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              op_ok;
		logic              linked;
		logic              undirected;
		logic              same_vertex;
		logic              n_zero;
		logic              row_last_sweep;
		logic              row_last_scan;
		logic              chunk_last;
		logic              out_busy;
		logic              cfg_clr;
	} abme_stat_t;

endpackage
`default_nettype wire

@@ rtl/abme_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abme channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface abme_req_if import abme_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [VID_W-1:0]  from_vertex;
	logic [VID_W-1:0]  to_vertex;

	modport source (output valid, output func, output from_vertex, output to_vertex,
		input ready);
	modport sink (input valid, input func, input from_vertex, input to_vertex,
		output ready);
endinterface

interface abme_rsp_if import abme_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              connected;
	logic [CNT_W-1:0]  edge_total;

	modport source (output valid, output status, output connected, output edge_total,
		input ready);
	modport sink (input valid, input status, input connected, input edge_total,
		output ready);
endinterface

interface abme_cfg_if import abme_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/abme_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abme_ctrl
// Sequencer for the matrix engine: decodes each request and steps the
// datapath through row reads, row writes, the recount scan and clearing passes.
// ----------------------------------------------------------------------------
module abme_ctrl import abme_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  abme_stat_t stat,
	output abme_cmd_t  cmd,
	output logic       req_ready
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_EVA    = 4'd2;
	localparam logic [3:0] S_RDB    = 4'd3;
	localparam logic [3:0] S_WRB    = 4'd4;
	localparam logic [3:0] S_SC_RD  = 4'd5;
	localparam logic [3:0] S_SC_LD  = 4'd6;
	localparam logic [3:0] S_SC_CNT = 4'd7;
	localparam logic [3:0] S_SC_END = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;
	localparam logic [3:0] S_SWEEP  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       edge_write;

	// An add of an absent edge or a removal of a present one changes the store.
	assign edge_write = stat.op_ok &&
		(((stat.func == FN_ADD) && !stat.linked) ||
		((stat.func == FN_REMOVE) && stat.linked));

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (stat.cfg_clr) begin
					cmd.row_clr = 1'b1;
					state_nxt   = S_SWEEP;
				end else begin
					req_ready = 1'b1;
					if (req_valid) begin
						cmd.item_ld = 1'b1;
						state_nxt   = S_DEC;
					end
				end
			end
			S_DEC: begin
				cmd.eval   = 1'b1;
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RS_ROW_A;
				case (stat.func)
					FN_ADD, FN_REMOVE, FN_QUERY: begin
						state_nxt = S_EVA;
					end
					FN_RECOUNT: begin
						cmd.row_clr = 1'b1;
						cmd.acc_clr = 1'b1;
						if (stat.n_zero) begin
							cmd.cnt_op = CO_CLR;
							state_nxt  = S_DONE;
						end else begin
							state_nxt = S_SC_RD;
						end
					end
					FN_CLEAR: begin
						cmd.cnt_op  = CO_CLR;
						cmd.row_clr = 1'b1;
						state_nxt   = S_DONE;
					end
					default: begin
						state_nxt = S_DONE;
					end
				endcase
			end
			S_EVA: begin
				cmd.eval  = 1'b1;
				state_nxt = S_DONE;
				if (edge_write) begin
					cmd.mem_wr = 1'b1;
					cmd.wr_sel = WS_ROW_A;
					cmd.cnt_op = (stat.func == FN_ADD) ? CO_INC : CO_DEC;
					if (stat.undirected && !stat.same_vertex) begin
						state_nxt = S_RDB;
					end
				end
			end
			S_RDB: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RS_ROW_B;
				state_nxt  = S_WRB;
			end
			S_WRB: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = WS_ROW_B;
				state_nxt  = S_DONE;
			end
			S_SC_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = RS_ROW_CNT;
				state_nxt  = S_SC_LD;
			end
			S_SC_LD: begin
				cmd.row_ld = 1'b1;
				state_nxt  = S_SC_CNT;
			end
			S_SC_CNT: begin
				cmd.chunk_step = 1'b1;
				if (stat.chunk_last) begin
					cmd.row_inc = 1'b1;
					state_nxt   = stat.row_last_scan ? S_SC_END : S_SC_RD;
				end
			end
			S_SC_END: begin
				cmd.cnt_op = CO_LOAD;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.res_ld = 1'b1;
					state_nxt  = (stat.func == FN_CLEAR) ? S_SWEEP : S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = WS_ZERO;
				if (stat.cfg_clr) begin
					cmd.row_clr = 1'b1;
				end else begin
					cmd.row_inc = 1'b1;
					if (stat.row_last_sweep) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// The store holds garbage after reset, so the block starts with a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a previous one is still in work");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (state_q == S_IDLE))
		else $error("request channel ready outside the idle state");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q <= S_SWEEP))
		else $error("sequencer in an unknown state");

endmodule
`default_nettype wire

@@ rtl/abme_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// abme_dpath
// Row memory, edge counter, configuration registers, status checks, the
// chunked population count for recounts, and the response register.
// ----------------------------------------------------------------------------
module abme_dpath import abme_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [FUNC_W-1:0]     req_func,
	input  logic [VID_W-1:0]      req_from,
	input  logic [VID_W-1:0]      req_to,
	input  logic                  rsp_ready,
	input  abme_cmd_t             cmd,
	output abme_stat_t            stat,
	output logic                  rsp_valid,
	output logic [STAT_W-1:0]     rsp_status,
	output logic                  rsp_connected,
	output logic [CNT_W-1:0]      rsp_edge_total
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int CH  = (MAX_VERTICES < CHUNK_MAX) ? MAX_VERTICES : CHUNK_MAX;
	localparam int NCH = (MAX_VERTICES + CH - 1) / CH;
	localparam int SHW = NCH * CH;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PCW = $clog2(CH + 1);
	localparam logic [VCNT_W-1:0] VMAX = VCNT_W'(MAX_VERTICES);

	logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] rd_q;

	logic [VCNT_W-1:0] vc_q;
	logic              dir_q;
	logic              self_q;
	logic [FUNC_W-1:0] func_q;
	logic [VID_W-1:0]  a_q;
	logic [VID_W-1:0]  b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  acc_q;
	logic [VW-1:0]     row_q;
	logic [CW-1:0]     chunk_q;
	logic [SHW-1:0]    sh_q;
	logic [STAT_W-1:0] op_status_q;
	logic              conn_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic              res_conn_q;
	logic [CNT_W-1:0]  res_total_q;

	logic [VCNT_W-1:0]       n_w;
	logic [NSQ_W-1:0]        nsq_w;
	logic                    full_w;
	logic                    empty_w;
	logic [STAT_W-1:0]       vcheck_w;
	logic [STAT_W-1:0]       status_w;
	logic [VW-1:0]           a_idx;
	logic [VW-1:0]           b_idx;
	logic                    linked_w;
	logic [MAX_VERTICES-1:0] colmask_w;
	logic [PCW-1:0]          pc_w;
	logic [VW-1:0]           rd_addr;
	logic [VW-1:0]           wr_addr;
	logic [MAX_VERTICES-1:0] wr_data;
	logic                    set_w;
	logic                    cfg_hit;

	// Vertex counts beyond the matrix size act as the matrix size.
	assign n_w     = (32'(vc_q) > MAX_VERTICES) ? VMAX : vc_q;
	assign nsq_w   = NSQ_W'(n_w) * NSQ_W'(n_w);
	assign full_w  = (NSQ_W'(cnt_q) == nsq_w);
	assign empty_w = (cnt_q == '0);
	assign a_idx   = VW'(a_q);
	assign b_idx   = VW'(b_q);
	// Undirected edges are always written to both mirror bits, so the
	// forward bit alone tells whether the pair is linked.
	assign linked_w = rd_q[b_idx];
	assign set_w    = (func_q == FN_ADD);

	always_comb begin
		if ((VCNT_W'(a_q) >= n_w) || (VCNT_W'(b_q) >= n_w)) begin
			vcheck_w = ST_RANGE;
		end else if ((a_q == b_q) && !self_q) begin
			vcheck_w = ST_SELF;
		end else begin
			vcheck_w = ST_OK;
		end
	end

	always_comb begin
		case (func_q)
			FN_ADD:    status_w = full_w ? ST_FULL : vcheck_w;
			FN_REMOVE: status_w = empty_w ? ST_EMPTY : vcheck_w;
			FN_QUERY:  status_w = vcheck_w;
			default:   status_w = ST_OK;
		endcase
	end

	always_comb begin
		for (int j = 0; j < MAX_VERTICES; j++) begin
			colmask_w[j] = (32'(j) < 32'(n_w));
		end
	end

	always_comb begin
		pc_w = '0;
		for (int k = 0; k < CH; k++) begin
			pc_w = pc_w + PCW'(sh_q[k]);
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RS_ROW_A: rd_addr = a_idx;
			RS_ROW_B: rd_addr = b_idx;
			default:  rd_addr = row_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WS_ROW_A: begin
				wr_addr = a_idx;
				wr_data = set_w ? (rd_q | (MAX_VERTICES'(1) << b_idx))
					: (rd_q & ~(MAX_VERTICES'(1) << b_idx));
			end
			WS_ROW_B: begin
				wr_addr = b_idx;
				wr_data = set_w ? (rd_q | (MAX_VERTICES'(1) << a_idx))
					: (rd_q & ~(MAX_VERTICES'(1) << a_idx));
			end
			default: begin
				wr_addr = row_q;
				wr_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign cfg_hit = cfg_valid && ((cfg_index == REG_VERTEX_COUNT) ||
		(cfg_index == REG_DIRECTED) || (cfg_index == REG_SELF_LOOPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q   <= VCNT_RST;
			dir_q  <= DIRECTED_RST;
			self_q <= SELF_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vc_q   <= cfg_data[VCNT_W-1:0];
				REG_DIRECTED:     dir_q  <= cfg_data[0];
				REG_SELF_LOOPS:   self_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			func_q <= req_func;
			a_q    <= req_from;
			b_q    <= req_to;
		end
		if (cmd.eval) begin
			op_status_q <= status_w;
			conn_q      <= (func_q == FN_QUERY) && (status_w == ST_OK) && linked_w;
		end
		if (cmd.row_ld) begin
			sh_q <= SHW'(rd_q & colmask_w);
		end else if (cmd.chunk_step) begin
			sh_q <= sh_q >> CH;
		end
		if (cmd.res_ld) begin
			res_status_q <= op_status_q;
			res_conn_q   <= conn_q;
			res_total_q  <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			acc_q       <= '0;
			row_q       <= '0;
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_hit) begin
				cnt_q <= '0;
			end else begin
				case (cmd.cnt_op)
					CO_INC:  cnt_q <= cnt_q + CNT_W'(1);
					CO_DEC:  cnt_q <= cnt_q - CNT_W'(1);
					CO_CLR:  cnt_q <= '0;
					// Undirected edges were seen from both ends.
					CO_LOAD: cnt_q <= dir_q ? acc_q : (acc_q >> 1);
					default: cnt_q <= cnt_q;
				endcase
			end
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end else if (cmd.chunk_step) begin
				acc_q <= acc_q + CNT_W'(pc_w);
			end
			if (cmd.row_clr) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + VW'(1);
			end
			if (cmd.row_ld) begin
				chunk_q <= '0;
			end else if (cmd.chunk_step) begin
				chunk_q <= chunk_q + CW'(1);
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.func           = func_q;
		stat.op_ok          = (status_w == ST_OK);
		stat.linked         = linked_w;
		stat.undirected     = !dir_q;
		stat.same_vertex    = (a_q == b_q);
		stat.n_zero         = (n_w == '0);
		stat.row_last_sweep = (row_q == VW'(MAX_VERTICES - 1));
		stat.row_last_scan  = (32'(row_q) == (32'(n_w) - 32'd1));
		stat.chunk_last     = (chunk_q == CW'(NCH - 1));
		stat.out_busy       = out_valid_q && !rsp_ready;
		stat.cfg_clr        = cfg_hit;
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_status     = res_status_q;
	assign rsp_connected  = res_conn_q;
	assign rsp_edge_total = res_total_q;

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> !(out_valid_q && !rsp_ready))
		else $error("response register loaded while holding an untaken beat");

	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CO_INC) |-> (NSQ_W'(cnt_q) != nsq_w))
		else $error("edge counter incremented on a full graph");

	a_dec_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CO_DEC) |-> (cnt_q != '0))
		else $error("edge counter decremented on an empty graph");

endmodule
`default_nettype wire

@@ rtl/adjacency_bit_matrix_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_bit_matrix_engine
// Vertex-by-vertex bit matrix with an edge counter: add, remove, query,
// recount and clear operations, one response beat per request beat.
// ----------------------------------------------------------------------------
// The matrix lives in a single-port row memory of MAX_VERTICES rows, so every
// operation is a short sequence of row reads and writes and one request is in
// work at a time; the response register lets the next request be taken while
// the last response waits. An add or remove that changes an undirected edge
// between two distinct vertices also rewrites the mirror row; a query, an add
// or remove in directed mode or on a self loop, and a rejected or unchanged
// edge operation touch one row only. A recount walks the first n rows (n the
// vertex count in use), each row costing a read, a load and a population count
// in chunks of up to 8 bits. A clear, every configuration write to a defined
// register and the end of reset start a clearing pass over all MAX_VERTICES
// rows, one row a cycle, during which no request is taken. The configuration
// port is always ready and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module adjacency_bit_matrix_engine import abme_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	abme_cfg_if.sink     cfg,
	abme_req_if.sink     req,
	abme_rsp_if.source   rsp
);

	abme_cmd_t  cmd;
	abme_stat_t stat;
	logic       req_ready;

	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;

	abme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.stat      (stat),
		.cmd       (cmd),
		.req_ready (req_ready)
	);

	abme_dpath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.req_func       (req.func),
		.req_from       (req.from_vertex),
		.req_to         (req.to_vertex),
		.rsp_ready      (rsp.ready),
		.cmd            (cmd),
		.stat           (stat),
		.rsp_valid      (rsp.valid),
		.rsp_status     (rsp.status),
		.rsp_connected  (rsp.connected),
		.rsp_edge_total (rsp.edge_total)
	);

endmodule
`default_nettype wire
